### rtl/core/typed_operand_stack_core_macros.svh
// assertion macros for the typed operand stack core
// used by the stack core sources; no other dependencies
`ifndef TYPED_OPERAND_STACK_CORE_MACROS_SVH
`define TYPED_OPERAND_STACK_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stack core assertion failed");
// next-cycle implication
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stack core assertion failed");
`else
`define TOS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/tos_pkg.sv
// shared constants and types for the typed operand stack core
// no dependencies
`timescale 1ns / 1ps

package tos_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int HEIGHT_W    = 9;

	// command codes
	localparam logic [3:0] CMD_PUSH  = 4'd0;
	localparam logic [3:0] CMD_POP   = 4'd1;
	localparam logic [3:0] CMD_PEEK  = 4'd2;
	localparam logic [3:0] CMD_SWAP  = 4'd3;
	localparam logic [3:0] CMD_PAIRS = 4'd4;
	localparam logic [3:0] CMD_ROT   = 4'd5;
	localparam logic [3:0] CMD_DUP   = 4'd6;
	localparam logic [3:0] CMD_DUP2  = 4'd7;
	localparam logic [3:0] CMD_DROP  = 4'd8;

	// element type codes
	localparam logic [1:0] TYPE_UNASSIGNED = 2'd0;
	localparam logic [1:0] TYPE_INT        = 2'd1;

	typedef struct packed {
		logic [1:0]  etype;
		logic [63:0] value;
		logic [15:0] level;
	} entry_t;

	// single-port memory request
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		entry_t            wdata;
	} ram_req_t;

endpackage

### rtl/core/tos_ram.sv
// single-port stack memory, registered read
// depends on tos_pkg
`timescale 1ns / 1ps

module tos_ram (
	input  logic              clk,
	input  tos_pkg::ram_req_t req,
	output tos_pkg::entry_t   rdata
);
	import tos_pkg::*;

	entry_t mem [STACK_DEPTH];
	entry_t rdata_q;

	// write or read, never both
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/typed_operand_stack_core.sv
// top level of the typed operand stack core: command sequencer and result register
// depends on tos_pkg, tos_ram and typed_operand_stack_core_macros.svh
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         in_valid / in_ready  cmd, push_type, push_value, push_level, amount
// result    out        out_valid/out_ready  out_type, out_value, out_level, underflow,
//                                           overflow, height, error_latched
//
// one command at a time through the single port of the stack memory: reads first,
// then a wait step if there were any reads, then writes, then the final step that
// loads the result register
// reset clears the internal height and sticky error; the memory has no clearing pass since
// entries above the height are never read
// a new request is taken while the previous result still waits; the next result
// holds in its final step until the result register is free

module typed_operand_stack_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         cmd,
	input  logic [1:0]         push_type,
	input  logic signed [63:0] push_value,
	input  logic [15:0]        push_level,
	input  logic [8:0]         amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_type,
	output logic signed [63:0] out_value,
	output logic [15:0]        out_level,
	output logic               underflow,
	output logic               overflow,
	output logic [8:0]         height,
	output logic               error_latched
);
	import tos_pkg::*;

	`include "typed_operand_stack_core_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	typedef struct packed {
		logic                under;
		logic                over;
		logic [2:0]          nrd;
		logic [2:0]          nwr;
		logic [HEIGHT_W-1:0] nh;
		logic [ADDR_W-1:0]   rbase;
		logic [ADDR_W-1:0]   wbase;
		logic                back;
	} decode_t;

	// read slot that feeds write j of a rearranging command
	function automatic logic [1:0] src_sel(input logic [3:0] c, input logic [1:0] j);
		logic [1:0] s;
		s = 2'd0;
		case (c)
			CMD_SWAP, CMD_DUP2: s = j ^ 2'd1;
			CMD_PAIRS:          s = j ^ 2'd2;
			CMD_ROT: begin
				case (j)
					2'd0:    s = 2'd1;
					2'd1:    s = 2'd2;
					default: s = 2'd0;
				endcase
			end
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	logic [2:0]          state_q;
	logic [1:0]          k_q;
	logic [HEIGHT_W-1:0] h_q;
	logic                err_q;
	decode_t             dec, dec_q;
	logic [3:0]          cmd_q;
	entry_t              push_q;
	entry_t              rd_q [4];
	logic                rd_vld_q;
	logic [1:0]          rd_idx_q;
	ram_req_t            ram_req;
	entry_t              rdata;
	logic                accept;
	logic                fin_go;

	logic                out_valid_q;
	logic [1:0]          out_type_q;
	logic [63:0]         out_value_q;
	logic [15:0]         out_level_q;
	logic                under_q;
	logic                over_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [HEIGHT_W-1:0] hm1;
	logic [HEIGHT_W-1:0] hpk;
	logic [HEIGHT_W:0]   hp2;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// command decode against the current height
	assign hm1 = h_q - HEIGHT_W'(1);
	assign hpk = h_q - amount - HEIGHT_W'(1);
	assign hp2 = {1'b0, h_q} + (HEIGHT_W + 1)'(2);

	always_comb begin
		dec       = '0;
		dec.nh    = h_q;
		dec.rbase = hm1[ADDR_W-1:0];
		dec.wbase = h_q[ADDR_W-1:0];
		case (cmd)
			CMD_PUSH: begin
				if (h_q >= HEIGHT_W'(STACK_DEPTH)) begin
					dec.over = 1'b1;
				end else begin
					dec.nwr = 3'd1;
					dec.nh  = h_q + HEIGHT_W'(1);
				end
			end
			CMD_POP: begin
				if (h_q == '0) begin
					dec.under = 1'b1;
				end else begin
					dec.nrd = 3'd1;
					dec.nh  = hm1;
				end
			end
			CMD_PEEK: begin
				if (h_q <= amount) begin
					dec.under = 1'b1;
				end else begin
					dec.nrd   = 3'd1;
					dec.rbase = hpk[ADDR_W-1:0];
				end
			end
			CMD_SWAP: begin
				if (h_q < HEIGHT_W'(2)) begin
					dec.under = 1'b1;
				end else begin
					dec.nrd   = 3'd2;
					dec.nwr   = 3'd2;
					dec.back  = 1'b1;
					dec.wbase = hm1[ADDR_W-1:0];
				end
			end
			CMD_PAIRS: begin
				if (h_q < HEIGHT_W'(4)) begin
					dec.under = 1'b1;
				end else begin
					dec.nrd   = 3'd4;
					dec.nwr   = 3'd4;
					dec.back  = 1'b1;
					dec.wbase = hm1[ADDR_W-1:0];
				end
			end
			CMD_ROT: begin
				if (h_q < HEIGHT_W'(3)) begin
					dec.under = 1'b1;
				end else begin
					dec.nrd   = 3'd3;
					dec.nwr   = 3'd3;
					dec.back  = 1'b1;
					dec.wbase = hm1[ADDR_W-1:0];
				end
			end
			CMD_DUP: begin
				if (h_q == '0) begin
					dec.under = 1'b1;
				end else if (h_q >= HEIGHT_W'(STACK_DEPTH)) begin
					dec.over = 1'b1;
				end else begin
					dec.nrd = 3'd1;
					dec.nwr = 3'd1;
					dec.nh  = h_q + HEIGHT_W'(1);
				end
			end
			CMD_DUP2: begin
				if (h_q < HEIGHT_W'(2)) begin
					dec.under = 1'b1;
				end else if (hp2 > (HEIGHT_W + 1)'(STACK_DEPTH)) begin
					dec.over = 1'b1;
				end else begin
					dec.nrd = 3'd2;
					dec.nwr = 3'd2;
					dec.nh  = hp2[HEIGHT_W-1:0];
				end
			end
			CMD_DROP: begin
				if (amount > h_q) begin
					dec.under = 1'b1;
					dec.nh    = '0;
				end else begin
					dec.nh = h_q - amount;
				end
			end
			default: begin
			end
		endcase
	end

	// memory request: reads walk down from the read base, writes follow the table
	always_comb begin
		ram_req       = '0;
		ram_req.wdata = push_q;
		if (state_q == ST_READ) begin
			ram_req.en   = 1'b1;
			ram_req.addr = dec_q.rbase - ADDR_W'(k_q);
		end else if (state_q == ST_WRITE) begin
			ram_req.en   = 1'b1;
			ram_req.we   = 1'b1;
			ram_req.addr = dec_q.back ? (dec_q.wbase - ADDR_W'(k_q))
			                          : (dec_q.wbase + ADDR_W'(k_q));
			if (cmd_q != CMD_PUSH) begin
				ram_req.wdata = rd_q[src_sel(cmd_q, k_q)];
			end
		end
	end

	tos_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			h_q      <= '0;
			err_q    <= 1'b0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			rd_vld_q <= (state_q == ST_READ);
			rd_idx_q <= k_q;
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept) begin
						if (dec.nrd != 3'd0) begin
							state_q <= ST_READ;
						end else if (dec.nwr != 3'd0) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_READ: begin
					if ({1'b0, k_q} == dec_q.nrd - 3'd1) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_WAIT: begin
					state_q <= (dec_q.nwr != 3'd0) ? ST_WRITE : ST_FIN;
				end
				ST_WRITE: begin
					if ({1'b0, k_q} == dec_q.nwr - 3'd1) begin
						k_q     <= '0;
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						h_q     <= dec_q.nh;
						if (dec_q.under) begin
							err_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields held for the command
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q        <= dec;
			cmd_q        <= cmd;
			push_q.etype <= push_type;
			push_q.value <= push_value;
			push_q.level <= push_level;
		end
	end

	// capture read data in the cycle after each read
	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			rd_q[rd_idx_q] <= rdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_type_q  <= TYPE_UNASSIGNED;
			out_value_q <= '0;
			out_level_q <= '0;
			under_q     <= dec_q.under;
			over_q      <= dec_q.over;
			height_q    <= dec_q.nh;
			if (cmd_q == CMD_POP) begin
				if (dec_q.under) begin
					out_type_q <= TYPE_INT;
				end else begin
					out_type_q  <= rd_q[0].etype;
					out_value_q <= rd_q[0].value;
					out_level_q <= rd_q[0].level;
				end
			end else if (cmd_q == CMD_PEEK && !dec_q.under) begin
				out_type_q <= rd_q[0].etype;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_type      = out_type_q;
	assign out_value     = out_value_q;
	assign out_level     = out_level_q;
	assign underflow     = under_q;
	assign overflow      = over_q;
	assign height        = height_q;
	assign error_latched = err_q;

	// checks on the sequencer
	`TOS_ASSERT_IMPL(height_in_range, clk, arst_n, 1'b1, h_q <= HEIGHT_W'(STACK_DEPTH))
	`TOS_ASSERT_IMPL(read_below_top, clk, arst_n, ram_req.en && !ram_req.we, HEIGHT_W'(ram_req.addr) < h_q)
	`TOS_ASSERT_IMPL(write_below_new_top, clk, arst_n, ram_req.en && ram_req.we, HEIGHT_W'(ram_req.addr) < dec_q.nh)
	`TOS_ASSERT_IMPL(flags_exclusive, clk, arst_n, out_valid_q, !(under_q && over_q))
	`TOS_ASSERT_NEXT(error_stays_set, clk, arst_n, err_q, err_q)

endmodule

### tb/tb_typed_operand_stack_core.sv
// self-checking testbench for typed_operand_stack_core: directed table, then random requests
// depends on tos_pkg and the stack core rtl; predicts every response in its own stack copy
`timescale 1ns / 1ps

module tb_typed_operand_stack_core;
	import tos_pkg::*;

	// element types not named in the package
	localparam logic [1:0] TYPE_FLOAT = 2'd2;
	localparam logic [1:0] TYPE_REF   = 2'd3;

	// codes with no command behind them
	localparam logic [3:0] CMD_UNUSED_MIN = 4'd9;
	localparam logic [3:0] CMD_UNUSED_MAX = 4'd15;

	localparam logic [63:0] VALUE_MAX_POS = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] VALUE_MIN_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] VALUE_ONES    = 64'hffff_ffff_ffff_ffff;
	localparam logic [8:0]  AMOUNT_MAX    = 9'd256;

	localparam int RANDOM_PER_PHASE = 500;
	localparam int PHASES           = 4;
	localparam int CYCLE_LIMIT      = 500000;
	localparam int SETTLE_CYCLES    = 30;
	localparam int MAX_REPORTS      = 10;
	localparam int DIRECTED_ROWS    = 25;

	typedef struct packed {
		logic [1:0]  etype;
		logic [63:0] value;
		logic [15:0] level;
		logic        under;
		logic        over;
		logic [8:0]  height;
		logic        err;
	} response_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [1:0]  ptype;
		logic [63:0] pvalue;
		logic [15:0] plevel;
		logic [8:0]  count;
		bit          known;
		response_t   resp;
	} table_row_t;

	localparam response_t NO_RESPONSE = '0;

	// directed requests; a typed response is used where known is set
	table_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{CMD_PEEK, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_POP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_INT, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_SWAP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_PAIRS, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_ROT, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_DUP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_DUP2, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_DROP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b0, 1'b0, 9'd0, 1'b1}},
		'{CMD_DROP, TYPE_UNASSIGNED, 64'd0, 16'd0, AMOUNT_MAX, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}},
		'{CMD_UNUSED_MAX, TYPE_REF, VALUE_ONES, 16'hffff, AMOUNT_MAX, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b0, 1'b0, 9'd0, 1'b1}},
		'{CMD_PUSH, TYPE_INT, VALUE_MAX_POS, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b0, 1'b0, 9'd1, 1'b1}},
		'{CMD_PUSH, TYPE_REF, VALUE_MIN_NEG, 16'hffff, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b0, 1'b0, 9'd2, 1'b1}},
		'{CMD_PUSH, TYPE_FLOAT, VALUE_ONES, 16'h8000, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b0, 1'b0, 9'd3, 1'b1}},
		'{CMD_PUSH, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b0, 1'b0, 9'd4, 1'b1}},
		'{CMD_PEEK, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd3, 1'b1,
			'{TYPE_INT, 64'd0, 16'd0, 1'b0, 1'b0, 9'd4, 1'b1}},
		'{CMD_PEEK, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd4, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd4, 1'b1}},
		'{CMD_SWAP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_PAIRS, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_ROT, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_DUP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_DUP2, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_POP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_POP, TYPE_UNASSIGNED, 64'd0, 16'd0, 9'd0, 1'b0, NO_RESPONSE},
		'{CMD_UNUSED_MIN, TYPE_INT, 64'd1, 16'd1, 9'd1, 1'b0, NO_RESPONSE},
		'{CMD_DROP, TYPE_UNASSIGNED, 64'd0, 16'd0, AMOUNT_MAX, 1'b1,
			'{TYPE_UNASSIGNED, 64'd0, 16'd0, 1'b1, 1'b0, 9'd0, 1'b1}}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         cmd;
	logic [1:0]         push_type;
	logic signed [63:0] push_value;
	logic [15:0]        push_level;
	logic [8:0]         amount;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         out_type;
	logic signed [63:0] out_value;
	logic [15:0]        out_level;
	logic               underflow;
	logic               overflow;
	logic [8:0]         height;
	logic               error_latched;

	// predicted stack contents
	entry_t    stack_copy [STACK_DEPTH];
	int        stack_height;
	logic      error_copy;
	response_t expected_responses [$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int fill_goal;
	int goal_age;
	int cycle_count;
	int checked_count;
	int mismatch_count;
	int underflow_count;
	int overflow_count;
	int peak_height;

	typed_operand_stack_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.push_type     (push_type),
		.push_value    (push_value),
		.push_level    (push_level),
		.amount        (amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_type      (out_type),
		.out_value     (out_value),
		.out_level     (out_level),
		.underflow     (underflow),
		.overflow      (overflow),
		.height        (height),
		.error_latched (error_latched)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
				expected_responses.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void exchange_entries(int a, int b);
		entry_t held;
		held = stack_copy[a];
		stack_copy[a] = stack_copy[b];
		stack_copy[b] = held;
	endfunction

	// next response of the stack, updating the predicted contents
	function automatic response_t predict_response(logic [3:0] op, logic [1:0] ptype,
			logic [63:0] pvalue, logic [15:0] plevel, logic [8:0] count);
		response_t r;
		int h;
		int n;
		r = '0;
		h = stack_height;
		n = int'(count);
		case (op)
			CMD_PUSH: begin
				if (h >= STACK_DEPTH) r.over = 1'b1;
				else begin
					stack_copy[h] = '{etype: ptype, value: pvalue, level: plevel};
					h++;
				end
			end
			CMD_POP: begin
				if (h == 0) begin
					r.under = 1'b1;
					r.etype = TYPE_INT;
				end else begin
					h--;
					r.etype = stack_copy[h].etype;
					r.value = stack_copy[h].value;
					r.level = stack_copy[h].level;
				end
			end
			CMD_PEEK: begin
				if (h <= n) r.under = 1'b1;
				else r.etype = stack_copy[h - n - 1].etype;
			end
			CMD_SWAP: begin
				if (h < 2) r.under = 1'b1;
				else exchange_entries(h - 1, h - 2);
			end
			CMD_PAIRS: begin
				if (h < 4) r.under = 1'b1;
				else begin
					exchange_entries(h - 1, h - 3);
					exchange_entries(h - 2, h - 4);
				end
			end
			CMD_ROT: begin
				// top slides under the next two
				if (h < 3) r.under = 1'b1;
				else begin
					exchange_entries(h - 1, h - 2);
					exchange_entries(h - 2, h - 3);
				end
			end
			CMD_DUP: begin
				if (h < 1) r.under = 1'b1;
				else if (h >= STACK_DEPTH) r.over = 1'b1;
				else begin
					stack_copy[h] = stack_copy[h - 1];
					h++;
				end
			end
			CMD_DUP2: begin
				if (h < 2) r.under = 1'b1;
				else if (h + 2 > STACK_DEPTH) r.over = 1'b1;
				else begin
					stack_copy[h] = stack_copy[h - 2];
					stack_copy[h + 1] = stack_copy[h - 1];
					h += 2;
				end
			end
			CMD_DROP: begin
				if (n > h) begin
					h = 0;
					r.under = 1'b1;
				end else h -= n;
			end
			default: ;
		endcase
		stack_height = h;
		if (r.under) error_copy = 1'b1;
		r.height = h[8:0];
		r.err = error_copy;
		return r;
	endfunction

	task automatic note_expected(response_t r);
		expected_responses.push_back(r);
		if (r.under) underflow_count++;
		if (r.over) overflow_count++;
		if (int'(r.height) > peak_height) peak_height = int'(r.height);
	endtask

	// present one request and hold it until the core takes it
	task automatic issue_request(logic [3:0] op, logic [1:0] ptype, logic [63:0] pvalue,
			logic [15:0] plevel, logic [8:0] count);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		push_type  <= ptype;
		push_value <= pvalue;
		push_level <= plevel;
		amount     <= count;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_responses();
		in_valid <= 1'b0;
		while (expected_responses.size() != 0) @(posedge clk);
	endtask

	// random request steered towards a moving fill goal
	task automatic send_random_request();
		logic [3:0]  op;
		logic [1:0]  ptype;
		logic [63:0] pvalue;
		logic [8:0]  count;
		int          pick;
		goal_age++;
		if (goal_age >= 400 || (stack_height == fill_goal && $urandom_range(9) == 0)) begin
			case ($urandom_range(3))
				0: fill_goal = 0;
				1: fill_goal = STACK_DEPTH;
				default: fill_goal = $urandom_range(STACK_DEPTH - 1, 1);
			endcase
			goal_age = 0;
		end
		pick = $urandom_range(99);
		if (pick < 5) op = 4'($urandom_range(CMD_UNUSED_MAX, CMD_UNUSED_MIN));
		else if (pick < 30) begin
			case ($urandom_range(3))
				0: op = CMD_PEEK;
				1: op = CMD_SWAP;
				2: op = CMD_PAIRS;
				default: op = CMD_ROT;
			endcase
		end else if (pick < 40) op = 4'($urandom_range(CMD_DROP, CMD_PUSH));
		else if (stack_height < fill_goal) begin
			case ($urandom_range(4))
				0: op = CMD_DUP;
				1: op = CMD_DUP2;
				default: op = CMD_PUSH;
			endcase
		end else if (stack_height > fill_goal) op = ($urandom_range(1) != 0) ? CMD_POP : CMD_DROP;
		else begin
			case ($urandom_range(4))
				0: op = CMD_PUSH;
				1: op = CMD_DUP;
				2: op = CMD_DUP2;
				3: op = CMD_POP;
				default: op = CMD_DROP;
			endcase
		end

		// depth or count, mostly in reach of the current height
		if (op == CMD_DROP && stack_height > fill_goal && $urandom_range(3) != 0)
			count = 9'($urandom_range(stack_height - fill_goal, 1));
		else if (op == CMD_DROP && $urandom_range(1) != 0)
			count = 9'($urandom_range(3));
		else if (op == CMD_PEEK && $urandom_range(4) != 0)
			count = 9'($urandom_range(stack_height));
		else
			count = 9'($urandom_range(AMOUNT_MAX));

		ptype = 2'($urandom_range(3));
		case ($urandom_range(11))
			0: pvalue = VALUE_MAX_POS;
			1: pvalue = VALUE_MIN_NEG;
			2: pvalue = VALUE_ONES;
			3: pvalue = '0;
			default: pvalue = {$urandom, $urandom};
		endcase
		issue_request(op, ptype, pvalue, 16'($urandom_range(16'hffff)), count);
		note_expected(predict_response(op, ptype, pvalue, push_level, count));
	endtask

	// response side: random stalls, every response checked against the oldest prediction
	always @(posedge clk) begin
		response_t seen;
		response_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{out_type, out_value, out_level, underflow, overflow, height,
					error_latched};
				checked_count++;
				if (expected_responses.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("response %0d arrived with none predicted", checked_count);
				end else begin
					want = expected_responses.pop_front();
					if (seen.etype !== want.etype || seen.value !== want.value ||
							seen.level !== want.level || seen.under !== want.under ||
							seen.over !== want.over || seen.height !== want.height ||
							seen.err !== want.err) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("response %0d expected type %0d value %h level %h uf %b of %b height %0d err %b",
								checked_count, want.etype, want.value, want.level, want.under,
								want.over, want.height, want.err);
							$display("response %0d got      type %0d value %h level %h uf %b of %b height %0d err %b",
								checked_count, seen.etype, seen.value, seen.level, seen.under,
								seen.over, seen.height, seen.err);
						end
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// idling per random phase: none, sender, receiver, both
	int phase_idle  [PHASES] = '{0, 71, 0, 32};
	int phase_stall [PHASES] = '{0, 0, 71, 32};

	initial begin
		response_t predicted;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		out_ready          = 1'b0;
		cmd                = CMD_PUSH;
		push_type          = TYPE_UNASSIGNED;
		push_value         = '0;
		push_level         = '0;
		amount             = '0;
		stack_height       = 0;
		error_copy         = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		fill_goal          = STACK_DEPTH;
		goal_age           = 0;
		cycle_count        = 0;
		checked_count      = 0;
		mismatch_count     = 0;
		underflow_count    = 0;
		overflow_count     = 0;
		peak_height        = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			issue_request(directed_rows[i].op, directed_rows[i].ptype, directed_rows[i].pvalue,
				directed_rows[i].plevel, directed_rows[i].count);
			predicted = predict_response(directed_rows[i].op, directed_rows[i].ptype,
				directed_rows[i].pvalue, directed_rows[i].plevel, directed_rows[i].count);
			note_expected(directed_rows[i].known ? directed_rows[i].resp : predicted);
		end

		// random phases, each closed by a pause until the core has answered everything
		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct    = phase_idle[p];
			receiver_stall_pct = phase_stall[p];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_request();
			wait_for_responses();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d requests (%0d from the table), %0d responses checked, %0d mismatches",
			DIRECTED_ROWS + PHASES * RANDOM_PER_PHASE, DIRECTED_ROWS, checked_count,
			mismatch_count);
		$display("predicted %0d underflows and %0d overflows, peak height %0d of %0d",
			underflow_count, overflow_count, peak_height, STACK_DEPTH);
		if (mismatch_count == 0 && expected_responses.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
